// ----- src/ihsc_pkg.sv -----
// shared types, character codes and helpers for the if header syntax checker
package ihsc_pkg;

	// parser phases
	typedef enum logic [3:0] {
		PH_LEAD,
		PH_TAG,
		PH_BETWEEN,
		PH_LIST,
		PH_NOT_N,
		PH_NOT_O,
		PH_NOT_T,
		PH_NOT_BLANK,
		PH_TOKEN,
		PH_ETAG_OPEN,
		PH_ETAG_W,
		PH_ETAG_Q,
		PH_ETAG_BODY,
		PH_ETAG_CLOSE
	} phase_t;

	// character codes used by the grammar
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UP_N   = 8'h4E;
	localparam logic [7:0] CH_UP_W   = 8'h57;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LO_O   = 8'h6F;
	localparam logic [7:0] CH_LO_T   = 8'h74;
	localparam logic [7:0] CH_DEL    = 8'h7F;

	// width of the reported byte offset
	localparam int OFF_W = 12;

	// parser flags and phase, position kept apart since its width follows MAX_LEN
	typedef struct packed {
		phase_t phase;
		logic   tag_form;
		logic   cond_seen;
		logic   list_seen;
		logic   nonempty;
		logic   err;
	} pstate_t;

	localparam pstate_t PSTATE_RESET = '{
		phase:     PH_LEAD,
		tag_form:  1'b0,
		cond_seen: 1'b0,
		list_seen: 1'b0,
		nonempty:  1'b0,
		err:       1'b0
	};

	// input item
	typedef struct packed {
		logic [7:0] ch;
		logic       has_char;
		logic       last;
	} hdr_t;

	// result item
	typedef struct packed {
		logic [OFF_W-1:0] byte_offset;
		logic             ref_open;
		logic             ref_close;
		logic             failed;
		logic             tagged_form;
		logic             done_res;
		logic             accepted;
	} res_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	// characters not allowed inside angle brackets
	function automatic logic angle_bad(input logic [7:0] c);
		return (c <= CH_SPACE) || (c == CH_DEL) || (c == CH_LT);
	endfunction

endpackage

// ----- src/ihsc_stream_if.sv -----
// valid/ready stream interface with a typed payload
interface ihsc_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- src/ihsc_parse.sv -----
// one parser step: next state and result for one header item
module ihsc_parse #(
	parameter int MAX_LEN = 4096,
	parameter int POS_W   = 13
) (
	input  ihsc_pkg::pstate_t  st,
	input  logic [POS_W-1:0]   pos,
	input  ihsc_pkg::hdr_t     item,
	output ihsc_pkg::pstate_t  st_nxt,
	output logic [POS_W-1:0]   pos_nxt,
	output ihsc_pkg::res_t     res
);

	ihsc_pkg::pstate_t ns;
	logic [POS_W-1:0]  np;
	logic              open_b;
	logic              close_b;
	logic [7:0]        c;
	logic              acc;

	assign c = item.ch;

	// grammar step
	always_comb begin
		ns      = st;
		np      = pos;
		open_b  = 1'b0;
		close_b = 1'b0;
		if (item.has_char) begin
			if (pos >= POS_W'(MAX_LEN)) begin
				ns.err = 1'b1;
			end else begin
				if (!st.err) begin
					case (st.phase)
						ihsc_pkg::PH_LEAD: begin
							if (ihsc_pkg::is_blank(c)) begin
							end else if (c == ihsc_pkg::CH_LT) begin
								ns.tag_form = 1'b1;
								ns.nonempty = 1'b0;
								ns.phase    = ihsc_pkg::PH_TAG;
								open_b      = 1'b1;
							end else if (c == ihsc_pkg::CH_LPAREN) begin
								ns.tag_form  = 1'b0;
								ns.cond_seen = 1'b0;
								ns.phase     = ihsc_pkg::PH_LIST;
							end else begin
								ns.err = 1'b1;
							end
						end
						ihsc_pkg::PH_TAG: begin
							if (c == ihsc_pkg::CH_GT) begin
								if (!st.nonempty) begin
									ns.err = 1'b1;
								end else begin
									ns.list_seen = 1'b0;
									ns.phase     = ihsc_pkg::PH_BETWEEN;
									close_b      = 1'b1;
								end
							end else if (ihsc_pkg::angle_bad(c)) begin
								ns.err = 1'b1;
							end else begin
								ns.nonempty = 1'b1;
							end
						end
						ihsc_pkg::PH_BETWEEN: begin
							if (ihsc_pkg::is_blank(c)) begin
							end else if (c == ihsc_pkg::CH_LPAREN) begin
								ns.cond_seen = 1'b0;
								ns.phase     = ihsc_pkg::PH_LIST;
							end else if (c == ihsc_pkg::CH_LT && st.tag_form && st.list_seen) begin
								ns.nonempty = 1'b0;
								ns.phase    = ihsc_pkg::PH_TAG;
								open_b      = 1'b1;
							end else begin
								ns.err = 1'b1;
							end
						end
						ihsc_pkg::PH_LIST, ihsc_pkg::PH_NOT_BLANK: begin
							if (ihsc_pkg::is_blank(c)) begin
							end else if (st.phase == ihsc_pkg::PH_LIST
									&& c == ihsc_pkg::CH_RPAREN) begin
								if (!st.cond_seen) begin
									ns.err = 1'b1;
								end else begin
									ns.list_seen = 1'b1;
									ns.phase     = ihsc_pkg::PH_BETWEEN;
								end
							end else if (st.phase == ihsc_pkg::PH_LIST
									&& c == ihsc_pkg::CH_UP_N) begin
								ns.phase = ihsc_pkg::PH_NOT_N;
							end else if (c == ihsc_pkg::CH_LT) begin
								// condition opens with a state token
								ns.nonempty = 1'b0;
								ns.phase    = ihsc_pkg::PH_TOKEN;
							end else if (c == ihsc_pkg::CH_LBRACK) begin
								ns.phase = ihsc_pkg::PH_ETAG_OPEN;
							end else begin
								ns.err = 1'b1;
							end
						end
						ihsc_pkg::PH_NOT_N: begin
							if (c == ihsc_pkg::CH_LO_O) ns.phase = ihsc_pkg::PH_NOT_O;
							else ns.err = 1'b1;
						end
						ihsc_pkg::PH_NOT_O: begin
							if (c == ihsc_pkg::CH_LO_T) ns.phase = ihsc_pkg::PH_NOT_T;
							else ns.err = 1'b1;
						end
						ihsc_pkg::PH_NOT_T: begin
							if (ihsc_pkg::is_blank(c)) ns.phase = ihsc_pkg::PH_NOT_BLANK;
							else ns.err = 1'b1;
						end
						ihsc_pkg::PH_TOKEN: begin
							if (c == ihsc_pkg::CH_GT) begin
								if (!st.nonempty) begin
									ns.err = 1'b1;
								end else begin
									ns.cond_seen = 1'b1;
									ns.phase     = ihsc_pkg::PH_LIST;
								end
							end else if (ihsc_pkg::angle_bad(c)) begin
								ns.err = 1'b1;
							end else begin
								ns.nonempty = 1'b1;
							end
						end
						ihsc_pkg::PH_ETAG_OPEN: begin
							if (c == ihsc_pkg::CH_UP_W) ns.phase = ihsc_pkg::PH_ETAG_W;
							else if (c == ihsc_pkg::CH_DQUOTE) ns.phase = ihsc_pkg::PH_ETAG_BODY;
							else ns.err = 1'b1;
						end
						ihsc_pkg::PH_ETAG_W: begin
							if (c == ihsc_pkg::CH_SLASH) ns.phase = ihsc_pkg::PH_ETAG_Q;
							else ns.err = 1'b1;
						end
						ihsc_pkg::PH_ETAG_Q: begin
							if (c == ihsc_pkg::CH_DQUOTE) ns.phase = ihsc_pkg::PH_ETAG_BODY;
							else ns.err = 1'b1;
						end
						ihsc_pkg::PH_ETAG_BODY: begin
							if (c == ihsc_pkg::CH_DQUOTE) ns.phase = ihsc_pkg::PH_ETAG_CLOSE;
							else if (c <= ihsc_pkg::CH_SPACE || c == ihsc_pkg::CH_DEL) ns.err = 1'b1;
						end
						ihsc_pkg::PH_ETAG_CLOSE: begin
							if (c == ihsc_pkg::CH_RBRACK) begin
								ns.cond_seen = 1'b1;
								ns.phase     = ihsc_pkg::PH_LIST;
							end else begin
								ns.err = 1'b1;
							end
						end
						default: begin
							ns.err = 1'b1;
						end
					endcase
				end
				np = pos + POS_W'(1);
			end
			// no markers once the header has failed
			if (ns.err) begin
				open_b  = 1'b0;
				close_b = 1'b0;
			end
		end
	end

	// acceptance on the last item
	assign acc = item.last && !ns.err &&
		((ns.phase == ihsc_pkg::PH_BETWEEN && ns.list_seen) ||
		 (ns.phase == ihsc_pkg::PH_LEAD && np == '0));

	// result fields
	always_comb begin
		res.byte_offset = ihsc_pkg::OFF_W'(pos);
		res.ref_open    = open_b;
		res.ref_close   = close_b;
		res.failed      = ns.err;
		res.tagged_form = ns.tag_form;
		res.done_res    = item.last;
		res.accepted    = acc;
	end

	// a new header starts after the last item
	assign st_nxt  = item.last ? ihsc_pkg::PSTATE_RESET : ns;
	assign pos_nxt = item.last ? '0 : np;

endmodule

// ----- src/if_header_syntax_checker_core.sv -----
// Results go through the input register and the result register and are held until taken.
// Throughput: one header byte per cycle unless results stall; parser state loops through st_q.
// An input register and a result register part the two sides, so stalls leave no gap.
// Reset (arst_n low, asynchronous) empties both registers and returns the parser to the
// leading blanks phase with all flags and the byte position cleared.
module if_header_syntax_checker_core #(
	parameter int MAX_LEN = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	ihsc_stream_if.sink         hdr,
	ihsc_stream_if.source       res
);

	localparam int POS_W = $clog2(MAX_LEN + 1);

	ihsc_pkg::hdr_t    item_s1;
	logic              valid_s1;
	ihsc_pkg::pstate_t st_q;
	logic [POS_W-1:0]  pos_q;
	ihsc_pkg::pstate_t st_nxt;
	logic [POS_W-1:0]  pos_nxt;
	ihsc_pkg::res_t    res_nxt;
	ihsc_pkg::res_t    res_q;
	logic              res_valid_q;
	logic              adv;

	// stage 1 moves into the result register when that is free or being emptied
	assign adv       = valid_s1 && (!res_valid_q || res.ready);
	assign hdr.ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hdr.valid && hdr.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr.valid && hdr.ready) begin
			item_s1 <= hdr.payload;
		end
	end

	ihsc_parse #(
		.MAX_LEN(MAX_LEN),
		.POS_W  (POS_W)
	) u_parse (
		.st     (st_q),
		.pos    (pos_q),
		.item   (item_s1),
		.st_nxt (st_nxt),
		.pos_nxt(pos_nxt),
		.res    (res_nxt)
	);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ihsc_pkg::PSTATE_RESET;
			pos_q <= '0;
		end else if (adv) begin
			st_q  <= st_nxt;
			pos_q <= pos_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.payload = res_q;

endmodule

// ----- src/ihsc_checker.sv -----
// port level checks for the if header syntax checker, bound to the top level
module ihsc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_ready,
	input ihsc_pkg::res_t out_res
);

	// a waiting result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a waiting result keeps its value
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_res))
		else $error("result changed while stalled");

	// acceptance only on the final result of a clean header
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_res.accepted |-> out_res.done_res && !out_res.failed)
		else $error("accepted without done or with failure");

	// tag markers only on good bytes, never both on one byte
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_res.ref_open || out_res.ref_close) |->
			!out_res.failed && !(out_res.ref_open && out_res.ref_close) && out_res.tagged_form)
		else $error("bad resource tag marker");

endmodule

bind if_header_syntax_checker_core ihsc_checker u_ihsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(res.valid),
	.out_ready(res.ready),
	.out_res  (res.payload)
);
